// ===== design/rit_pkg.sv =====
package rit_pkg;

  // Coordinate format: signed, CW bits, FB fraction bits.
  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int MW   = 32;            // matrix element width
  localparam int NREG = 6;
  localparam int IDXW = 3;
  localparam int REGW = 64;

  localparam int LW   = CW;            // length / root width
  localparam int SUMW = 2 * CW;        // sum of squares
  localparam int ACCW = MW + CW + 2;   // row accumulator
  localparam int NUMW = CW + FB + 1;   // normalize dividend
  localparam int RQW  = 2 * FB + 1;    // reciprocal quotient bits
  localparam int NQW  = FB + 2;        // normalize quotient bits

  // Register indexes
  localparam logic [IDXW-1:0] REG_R0_C01 = IDXW'(0);
  localparam logic [IDXW-1:0] REG_R0_C23 = IDXW'(1);
  localparam logic [IDXW-1:0] REG_R1_C01 = IDXW'(2);
  localparam logic [IDXW-1:0] REG_R1_C23 = IDXW'(3);
  localparam logic [IDXW-1:0] REG_R2_C01 = IDXW'(4);
  localparam logic [IDXW-1:0] REG_R2_C23 = IDXW'(5);

  localparam logic [CW-2:0] LMAX = {(CW-1){1'b1}};

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t [2:0]         coord3_t;
  typedef logic signed [MW-1:0] melem_t;
  typedef melem_t [3:0]         mrow_t;
  typedef mrow_t [2:0]          mat_t;

  // Transformed ray, before length
  typedef struct packed {
    coord3_t o;
    coord3_t d;
    coord_t  mt;
  } xf_t;

  // Transformed ray with its length
  typedef struct packed {
    coord3_t         o;
    coord3_t         d;
    coord_t          mt;
    logic            zero;
    logic [LW-1:0]   len;
  } ln_t;

  // Final result word
  typedef struct packed {
    coord3_t       o;
    coord3_t       nd;
    coord_t        mt;
    logic [CW-2:0] len;
    logic [CW-2:0] inv;
    logic          zero;
  } res_t;

  // Round half up at FB, then saturate to CW bits.
  function automatic coord_t rnd_sat(input logic signed [ACCW-1:0] a);
    logic signed [ACCW-1:0] s;
    logic signed [ACCW-1:0] cmax;
    logic signed [ACCW-1:0] cmin;
    cmax = $signed({{(ACCW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    cmin = ~cmax;
    s = a + $signed({{(ACCW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}});
    s = s >>> FB;
    if (s > cmax) begin
      return cmax[CW-1:0];
    end else if (s < cmin) begin
      return cmin[CW-1:0];
    end
    return s[CW-1:0];
  endfunction

endpackage

// ===== design/rit_xform.sv =====
module rit_xform import rit_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  mat_t    mat_i,
  input  coord3_t org_i,
  input  coord3_t dir_i,
  input  coord_t  mt_i,
  output logic    valid_o,
  output xf_t     xf_o
);

  logic signed [MW+CW-1:0] po_q [3][3];
  logic signed [MW+CW-1:0] pd_q [3][3];
  logic signed [MW+FB-1:0] pt_q [3];
  coord_t                  mt_q;
  logic                    va_q;
  logic                    vb_q;
  xf_t                     xf_q;

  logic signed [ACCW-1:0]  acco [3];
  logic signed [ACCW-1:0]  accd [3];
  xf_t                     xf_d;

  // stage A: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          po_q[r][c] <= $signed(mat_i[r][c]) * $signed(org_i[c]);
          pd_q[r][c] <= $signed(mat_i[r][c]) * $signed(dir_i[c]);
        end
        pt_q[r] <= $signed({mat_i[r][3], {FB{1'b0}}});
      end
      mt_q <= mt_i;
    end
  end

  // stage B: row sums, round, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acco[r] = ACCW'(po_q[r][0]) + ACCW'(po_q[r][1]) + ACCW'(po_q[r][2]) + ACCW'(pt_q[r]);
      accd[r] = ACCW'(pd_q[r][0]) + ACCW'(pd_q[r][1]) + ACCW'(pd_q[r][2]);
      xf_d.o[r] = rnd_sat(acco[r]);
      xf_d.d[r] = rnd_sat(accd[r]);
    end
    xf_d.mt = mt_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xf_q <= xf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  assign valid_o = vb_q;
  assign xf_o    = xf_q;

endmodule

// ===== design/rit_sqrt.sv =====
module rit_sqrt import rit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  xf_t  xf_i,
  output logic valid_o,
  output ln_t  ln_o
);

  localparam int SQN = LW;
  localparam int RW  = LW + 2;

  typedef struct packed {
    xf_t             xf;
    logic            zero;
    logic [SUMW-1:0] n;
    logic [RW-1:0]   rem;
    logic [LW-1:0]   root;
  } sst_t;

  // one root bit per stage
  function automatic sst_t sq_step(input sst_t s);
    sst_t            r;
    logic [RW+1:0]   t;
    logic [RW+1:0]   trial;
    r     = s;
    t     = {s.rem, s.n[SUMW-1 -: 2]};
    trial = (RW+2)'({s.root, 2'b01});
    if (t >= trial) begin
      r.rem  = RW'(t - trial);
      r.root = {s.root[LW-2:0], 1'b1};
    end else begin
      r.rem  = RW'(t);
      r.root = {s.root[LW-2:0], 1'b0};
    end
    r.n = s.n << 2;
    return r;
  endfunction

  logic [CW-1:0]   mag_d [3];
  logic [SUMW-1:0] sq_q  [3];
  xf_t             xf1_q;
  logic            zero1_q;
  logic            v1_q;
  sst_t            s2_q;
  logic            v2_q;
  sst_t            st_q [SQN];
  logic            vs_q [SQN];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag_d[r] = xf_i.d[r][CW-1] ? CW'(-xf_i.d[r]) : CW'(xf_i.d[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        sq_q[r] <= SUMW'(mag_d[r]) * SUMW'(mag_d[r]);
      end
      xf1_q   <= xf_i;
      zero1_q <= (xf_i.d[0] == '0) && (xf_i.d[1] == '0) && (xf_i.d[2] == '0);
      s2_q.xf   <= xf1_q;
      s2_q.zero <= zero1_q;
      s2_q.n    <= sq_q[0] + sq_q[1] + sq_q[2];
      s2_q.rem  <= '0;
      s2_q.root <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  for (genvar k = 0; k < SQN; k++) begin : g_step
    sst_t cur;
    logic cv;
    if (k == 0) begin : g_first
      assign cur = s2_q;
      assign cv  = v2_q;
    end else begin : g_next
      assign cur = st_q[k-1];
      assign cv  = vs_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= sq_step(cur);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k] <= 1'b0;
      end else if (en_i) begin
        vs_q[k] <= cv;
      end
    end
  end

  assign valid_o   = vs_q[SQN-1];
  assign ln_o.o    = st_q[SQN-1].xf.o;
  assign ln_o.d    = st_q[SQN-1].xf.d;
  assign ln_o.mt   = st_q[SQN-1].xf.mt;
  assign ln_o.zero = st_q[SQN-1].zero;
  assign ln_o.len  = st_q[SQN-1].root;

endmodule

// ===== design/rit_div.sv =====
module rit_div import rit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  ln_t  ln_i,
  output logic valid_o,
  output res_t res_o
);

  localparam int DN = RQW;

  typedef struct packed {
    coord3_t                  o;
    coord_t                   mt;
    logic [2:0]               neg;
    logic                     zero;
    logic [LW-1:0]            len;
    logic [RQW-1:0]           rn;
    logic [2:0][NUMW-1:0]     nn;
    logic [LW-1:0]            rr;
    logic [RQW-1:0]           qr;
    logic [2:0][LW-1:0]       rm;
    logic [2:0][NQW-1:0]      qn;
  } dst_t;

  // restoring step; quotient bit b of the reciprocal, and of the
  // normalized components once b is in their range
  function automatic dst_t dv_step(input dst_t s, input int b);
    dst_t          r;
    logic [LW:0]   t;
    r = s;
    t = {s.rr, s.rn[b]};
    if (t >= {1'b0, s.len}) begin
      r.rr = LW'(t - {1'b0, s.len});
      r.qr = {s.qr[RQW-2:0], 1'b1};
    end else begin
      r.rr = LW'(t);
      r.qr = {s.qr[RQW-2:0], 1'b0};
    end
    if (b < NQW) begin
      for (int i = 0; i < 3; i++) begin
        t = {s.rm[i], s.nn[i][b]};
        if (t >= {1'b0, s.len}) begin
          r.rm[i] = LW'(t - {1'b0, s.len});
          r.qn[i] = {s.qn[i][NQW-2:0], 1'b1};
        end else begin
          r.rm[i] = LW'(t);
          r.qn[i] = {s.qn[i][NQW-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  logic [CW-1:0]          mag_d [3];
  logic                   v0_q;
  coord3_t                o0_q;
  logic signed [ACCW-1:0] prod0_q;
  logic [2:0]             neg0_q;
  logic                   zero0_q;
  logic [LW-1:0]          len0_q;
  logic [RQW-1:0]         rn0_q;
  logic [2:0][NUMW-1:0]   nn0_q;
  dst_t                   s0;
  dst_t                   st_q [DN];
  logic                   vs_q [DN];
  dst_t                   fin;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag_d[r] = ln_i.d[r][CW-1] ? CW'(-ln_i.d[r]) : CW'(ln_i.d[r]);
    end
  end

  // setup stage: dividends and the distance product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o0_q    <= ln_i.o;
      prod0_q <= $signed(ln_i.mt) * $signed({1'b0, ln_i.len});
      zero0_q <= ln_i.zero;
      len0_q  <= ln_i.len;
      rn0_q   <= {1'b1, {(2*FB){1'b0}}} + RQW'(ln_i.len >> 1);
      for (int r = 0; r < 3; r++) begin
        neg0_q[r] <= ln_i.d[r][CW-1];
        nn0_q[r]  <= NUMW'({mag_d[r], {FB{1'b0}}}) + NUMW'(ln_i.len >> 1);
      end
    end
  end

  always_comb begin
    s0.o    = o0_q;
    s0.mt   = rnd_sat(prod0_q);
    s0.neg  = neg0_q;
    s0.zero = zero0_q;
    s0.len  = len0_q;
    s0.rn   = rn0_q;
    s0.nn   = nn0_q;
    s0.rr   = '0;
    s0.qr   = '0;
    s0.qn   = '0;
    for (int r = 0; r < 3; r++) begin
      s0.rm[r] = LW'(nn0_q[r] >> NQW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  for (genvar k = 0; k < DN; k++) begin : g_step
    dst_t cur;
    logic cv;
    if (k == 0) begin : g_first
      assign cur = s0;
      assign cv  = v0_q;
    end else begin : g_next
      assign cur = st_q[k-1];
      assign cv  = vs_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= dv_step(cur, DN - 1 - k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k] <= 1'b0;
      end else if (en_i) begin
        vs_q[k] <= cv;
      end
    end
  end

  assign fin     = st_q[DN-1];
  assign valid_o = vs_q[DN-1];

  // sign, saturation, zero-length override
  always_comb begin
    res_o.o    = fin.o;
    res_o.zero = fin.zero;
    if (fin.zero) begin
      res_o.nd  = '0;
      res_o.mt  = '0;
      res_o.len = '0;
      res_o.inv = LMAX;
    end else begin
      for (int r = 0; r < 3; r++) begin
        res_o.nd[r] = fin.neg[r] ? -CW'(fin.qn[r]) : CW'(fin.qn[r]);
      end
      res_o.mt  = fin.mt;
      res_o.len = (fin.len > LW'(LMAX)) ? LMAX : fin.len[CW-2:0];
      res_o.inv = (fin.qr > RQW'(LMAX)) ? LMAX : fin.qr[CW-2:0];
    end
  end

endmodule

// ===== design/ray_inverse_affine_transform.sv =====
// Channel  | Handshake                  | Word
// ---------+----------------------------+-------------------------------------------
// in       | in_valid_i / in_ready_o    | world_origin_*, world_dir_*, world_min_t
// out      | out_valid_o / out_ready_i  | obj_origin_*, obj_dir_*, obj_min_t,
//          |                            | dir_length, inv_dir_length, zero_length
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i (always ready)
//
// One word per cycle sustained while out is not stalled; registers from accept to out_valid_o:
// 2 transform, 2 square/sum + 32 square-root bit stages, 1 setup + 33 divider bit
// stages (reciprocal length, one quotient bit each), 1 output register.
// Reset clears valid bits and loads the identity matrix.
// A stall on out freezes the whole pipeline in place; in_ready_o drops only then.
module ray_inverse_affine_transform import rit_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input ray
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [CW-1:0]  world_origin_x_i,
  input  logic signed [CW-1:0]  world_origin_y_i,
  input  logic signed [CW-1:0]  world_origin_z_i,
  input  logic signed [CW-1:0]  world_dir_x_i,
  input  logic signed [CW-1:0]  world_dir_y_i,
  input  logic signed [CW-1:0]  world_dir_z_i,
  input  logic signed [CW-1:0]  world_min_t_i,
  // result
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [CW-1:0]  obj_origin_x_o,
  output logic signed [CW-1:0]  obj_origin_y_o,
  output logic signed [CW-1:0]  obj_origin_z_o,
  output logic signed [CW-1:0]  obj_dir_x_o,
  output logic signed [CW-1:0]  obj_dir_y_o,
  output logic signed [CW-1:0]  obj_dir_z_o,
  output logic signed [CW-1:0]  obj_min_t_o,
  output logic [CW-2:0]         dir_length_o,
  output logic [CW-2:0]         inv_dir_length_o,
  output logic                  zero_length_o,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IDXW-1:0]       cfg_index_i,
  input  logic [REGW-1:0]       cfg_data_i
);

  localparam logic [REGW-1:0] ONE_FX = REGW'(1) << FB;

  logic [REGW-1:0] regs_q [NREG];
  mat_t            mat;
  logic            en;
  coord3_t         org;
  coord3_t         dir;

  logic            xf_vld;
  xf_t             xf;
  logic            ln_vld;
  ln_t             ln;
  logic            rs_vld;
  res_t            rs;

  logic            out_valid_q;
  res_t            out_q;

  assign cfg_ready_o = 1'b1;

  // matrix registers; out-of-range index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[REG_R0_C01] <= ONE_FX;
      regs_q[REG_R0_C23] <= '0;
      regs_q[REG_R1_C01] <= ONE_FX << 32;
      regs_q[REG_R1_C23] <= '0;
      regs_q[REG_R2_C01] <= '0;
      regs_q[REG_R2_C23] <= ONE_FX;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i <= REG_R2_C23)) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // low half = even column, high half = odd column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = (c % 2 == 1) ? regs_q[r*2 + c/2][2*MW-1:MW]
                                 : regs_q[r*2 + c/2][MW-1:0];
      end
    end
  end

  // global advance: move whenever the output register can take a word
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign org = {world_origin_z_i, world_origin_y_i, world_origin_x_i};
  assign dir = {world_dir_z_i, world_dir_y_i, world_dir_x_i};

  rit_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (mat),
    .org_i   (org),
    .dir_i   (dir),
    .mt_i    (world_min_t_i),
    .valid_o (xf_vld),
    .xf_o    (xf)
  );

  rit_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (xf_vld),
    .xf_i    (xf),
    .valid_o (ln_vld),
    .ln_o    (ln)
  );

  rit_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ln_vld),
    .ln_i    (ln),
    .valid_o (rs_vld),
    .res_o   (rs)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rs_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= rs;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign obj_origin_x_o   = out_q.o[0];
  assign obj_origin_y_o   = out_q.o[1];
  assign obj_origin_z_o   = out_q.o[2];
  assign obj_dir_x_o      = out_q.nd[0];
  assign obj_dir_y_o      = out_q.nd[1];
  assign obj_dir_z_o      = out_q.nd[2];
  assign obj_min_t_o      = out_q.mt;
  assign dir_length_o     = out_q.len;
  assign inv_dir_length_o = out_q.inv;
  assign zero_length_o    = out_q.zero;

endmodule

// ===== design/rit_check.sv =====
module rit_check import rit_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic signed [CW-1:0] obj_origin_x_o,
  input logic signed [CW-1:0] obj_dir_x_o,
  input logic signed [CW-1:0] obj_dir_y_o,
  input logic signed [CW-1:0] obj_dir_z_o,
  input logic signed [CW-1:0] obj_min_t_o,
  input logic [CW-2:0]        dir_length_o,
  input logic [CW-2:0]        inv_dir_length_o,
  input logic                 zero_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(obj_origin_x_o) && $stable(dir_length_o))
    else $error("out word changed while stalled");

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> dir_length_o == '0 && inv_dir_length_o == LMAX
      && obj_dir_x_o == '0 && obj_dir_y_o == '0 && obj_dir_z_o == '0
      && obj_min_t_o == '0)
    else $error("zero-length word not saturated");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !zero_length_o |-> dir_length_o != '0)
    else $error("nonzero direction with zero length");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

endmodule

bind ray_inverse_affine_transform rit_check u_rit_check (.*);
